// File: hdl/smart_card_atr_parser_core_macros.svh
// ----------------------------------------------------------------------------
// ATR parser assertion macros
// Shared concurrent assertion helpers, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SMART_CARD_ATR_PARSER_CORE_MACROS_SVH
`define SMART_CARD_ATR_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ATR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ATR_ASSERT_SAME(label, ante, cons, msg)
`define ATR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/scatr_pkg.sv
// ----------------------------------------------------------------------------
// ATR parser package
// Types, codes and constants shared by the answer-to-reset parser.
// ----------------------------------------------------------------------------
package scatr_pkg;

  // Interface groups allowed before the ATR is rejected.
  localparam int MaxGroups = 8;
  localparam int GroupW    = $clog2(MaxGroups);

  // Legal initial characters: direct and inverse convention.
  localparam logic [7:0] TsDirect  = 8'h3B;
  localparam logic [7:0] TsInverse = 8'h3F;

  typedef enum logic [1:0] {
    PH_TS   = 2'd0,
    PH_T0   = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    CLS_TS      = 4'd0,
    CLS_T0      = 4'd1,
    CLS_TA      = 4'd2,
    CLS_TB      = 4'd3,
    CLS_TC      = 4'd4,
    CLS_TD      = 4'd5,
    CLS_HIST    = 4'd6,
    CLS_TCK     = 4'd7,
    CLS_IGNORED = 4'd8
  } class_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_BAD_TS    = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t              phase;
    logic [3:0]          pending;
    logic [3:0]          hist_left;
    logic [GroupW-1:0]   group;
    logic [7:0]          xor_acc;
    logic [3:0]          protocol;
    logic                tck_expected;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:        PH_TS,
    pending:      4'd0,
    hist_left:    4'd0,
    group:        '0,
    xor_acc:      8'd0,
    protocol:     4'd0,
    tck_expected: 1'b0
  };

  // Classification of one byte, minus the echoed byte itself.
  typedef struct packed {
    class_t      byte_class;
    logic [2:0]  group_number;
    status_t     parse_status;
    logic [3:0]  protocol_type;
  } step_result_t;

endpackage

// File: hdl/atr_byte_if.sv
// ----------------------------------------------------------------------------
// ATR byte channel
// Valid/ready channel carrying one received answer-to-reset byte.
// ----------------------------------------------------------------------------
interface atr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] atr_byte;
  logic       start_new;
  logic       last_available;

  modport source (output valid, output atr_byte, output start_new,
                  output last_available, input ready);
  modport sink   (input valid, input atr_byte, input start_new,
                  input last_available, output ready);
endinterface

// File: hdl/atr_result_if.sv
// ----------------------------------------------------------------------------
// ATR result channel
// Valid/ready channel carrying the classification of one ATR byte.
// ----------------------------------------------------------------------------
interface atr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [3:0] byte_class;
  logic [2:0] group_number;
  logic [2:0] parse_status;
  logic [3:0] protocol_type;

  modport source (output valid, output byte_value, output byte_class,
                  output group_number, output parse_status,
                  output protocol_type, input ready);
  modport sink   (input valid, input byte_value, input byte_class,
                  input group_number, input parse_status,
                  input protocol_type, output ready);
endinterface

// File: hdl/smart_card_atr_parser_core.sv
// ----------------------------------------------------------------------------
// Smart-card ATR parser core
// Classifies answer-to-reset bytes one per item and tracks the parse.
//
//   Channel  Dir  Payload                                         Handshake
//   atr      in   atr_byte, start_new, last_available             valid/ready
//   res      out  byte_value, byte_class, group_number,           valid/ready
//                 parse_status, protocol_type
//
// One byte is accepted per cycle unless a full output register that is not
// being taken holds off input; its result appears in the output register in
// the next cycle. The parser state updates at the accepting edge, so the next
// byte may follow immediately. Reset (rst, synchronous) returns the parser
// to expecting TS and empties the output register.
// ----------------------------------------------------------------------------
`include "smart_card_atr_parser_core_macros.svh"

module smart_card_atr_parser_core (
  input  logic          clk,
  input  logic          rst,
  atr_byte_if.sink      atr,
  atr_result_if.source  res
);

  scatr_pkg::parse_state_t state;
  scatr_pkg::parse_state_t state_next;
  scatr_pkg::step_result_t step;
  logic                    in_fire;

  // Input is taken whenever the output register is free or draining.
  assign atr.ready = !res.valid || res.ready;
  assign in_fire   = atr.valid && atr.ready;

  scatr_classify u_classify (
    .cur            (state),
    .atr_byte       (atr.atr_byte),
    .start_new      (atr.start_new),
    .last_available (atr.last_available),
    .nxt            (state_next),
    .res            (step)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scatr_pkg::StateReset;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (in_fire) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res.byte_value    <= atr.atr_byte;
      res.byte_class    <= step.byte_class;
      res.group_number  <= step.group_number;
      res.parse_status  <= step.parse_status;
      res.protocol_type <= step.protocol_type;
    end
  end

  // Checks on the parser's own behavior.
  `ATR_ASSERT_NEXT(a_result_follows, in_fire, res.valid, "accepted byte produced no result")
  `ATR_ASSERT_NEXT(a_terminal_done, in_fire && step.parse_status != scatr_pkg::ST_BUSY, state.phase == scatr_pkg::PH_DONE, "terminal status without finishing")
  `ATR_ASSERT_SAME(a_ignored_quiet, res.valid && res.byte_class == scatr_pkg::CLS_IGNORED, res.parse_status == scatr_pkg::ST_BUSY && res.group_number == 3'd0, "ignored byte reported status or group")
  `ATR_ASSERT_NEXT(a_ignored_keeps, in_fire && step.byte_class == scatr_pkg::CLS_IGNORED, $stable(state), "ignored byte changed state")

endmodule

// File: hdl/scatr_classify.sv
// ----------------------------------------------------------------------------
// ATR byte classifier
// Combinational step: classifies one byte against the current parser state
// and produces the next state and the result fields.
// ----------------------------------------------------------------------------
module scatr_classify (
  input  scatr_pkg::parse_state_t cur,
  input  logic [7:0]              atr_byte,
  input  logic                    start_new,
  input  logic                    last_available,
  output scatr_pkg::parse_state_t nxt,
  output scatr_pkg::step_result_t res
);

  scatr_pkg::parse_state_t st;
  scatr_pkg::parse_state_t upd;
  scatr_pkg::class_t       cls;
  logic [3:0]              td_pending;
  logic [7:0]              xor_new;
  logic                    group_full;
  logic                    bad_ts;
  logic                    overflow;
  logic                    term_early;
  logic                    complete;
  logic                    truncated;
  logic                    terminal;
  logic                    is_iface;

  // A start byte restarts the parser before the byte is looked at.
  assign st = start_new ? scatr_pkg::StateReset : cur;

  assign td_pending = atr_byte[7:4];
  assign xor_new    = st.xor_acc ^ atr_byte;
  assign group_full = (st.group == scatr_pkg::GroupW'(scatr_pkg::MaxGroups - 1));

  // Decide what this byte is from the phase and the indicators still due.
  always_comb begin
    cls = scatr_pkg::CLS_IGNORED;
    unique case (st.phase)
      scatr_pkg::PH_TS:   cls = scatr_pkg::CLS_TS;
      scatr_pkg::PH_T0:   cls = scatr_pkg::CLS_T0;
      scatr_pkg::PH_BODY: begin
        priority if (st.pending[0])        cls = scatr_pkg::CLS_TA;
        else if (st.pending[1])            cls = scatr_pkg::CLS_TB;
        else if (st.pending[2])            cls = scatr_pkg::CLS_TC;
        else if (st.pending[3])            cls = scatr_pkg::CLS_TD;
        else if (st.hist_left != 4'd0)     cls = scatr_pkg::CLS_HIST;
        else                               cls = scatr_pkg::CLS_TCK;
      end
      scatr_pkg::PH_DONE: cls = scatr_pkg::CLS_IGNORED;
      default:            cls = scatr_pkg::CLS_IGNORED;
    endcase
  end

  // Update the counters, indicators and checksum for this byte.
  always_comb begin
    upd = st;
    unique case (cls)
      scatr_pkg::CLS_T0: begin
        upd.xor_acc   = xor_new;
        upd.hist_left = atr_byte[3:0];
        upd.pending   = atr_byte[7:4];
      end
      scatr_pkg::CLS_TA: begin
        upd.xor_acc    = xor_new;
        upd.pending[0] = 1'b0;
      end
      scatr_pkg::CLS_TB: begin
        upd.xor_acc    = xor_new;
        upd.pending[1] = 1'b0;
      end
      scatr_pkg::CLS_TC: begin
        upd.xor_acc    = xor_new;
        upd.pending[2] = 1'b0;
      end
      scatr_pkg::CLS_TD: begin
        upd.xor_acc = xor_new;
        if (st.group == '0) begin
          upd.protocol = atr_byte[3:0];
        end
        if (atr_byte[3:0] != 4'd0) begin
          upd.tck_expected = 1'b1;
        end
        upd.pending = td_pending;
        if (td_pending != 4'd0 && !group_full) begin
          upd.group = st.group + 1'b1;
        end
      end
      scatr_pkg::CLS_HIST: begin
        upd.xor_acc   = xor_new;
        upd.hist_left = st.hist_left - 4'd1;
      end
      scatr_pkg::CLS_TCK: begin
        upd.xor_acc = xor_new;
      end
      default: begin
      end
    endcase
  end

  // Termination conditions, in order of precedence.
  assign bad_ts     = (cls == scatr_pkg::CLS_TS) && (atr_byte != scatr_pkg::TsDirect) &&
                      (atr_byte != scatr_pkg::TsInverse);
  assign overflow   = (cls == scatr_pkg::CLS_TD) && (td_pending != 4'd0) && group_full;
  assign term_early = bad_ts || overflow || (cls == scatr_pkg::CLS_TCK);
  assign complete   = (cls != scatr_pkg::CLS_IGNORED) && (cls != scatr_pkg::CLS_TS) &&
                      !term_early && (upd.pending == 4'd0) &&
                      (upd.hist_left == 4'd0) && !upd.tck_expected;
  assign truncated  = (cls != scatr_pkg::CLS_IGNORED) && !term_early && !complete &&
                      last_available;
  assign terminal   = term_early || complete || truncated;

  // Next state: the phase holds on an ignored byte, finishes on any terminal byte, or advances otherwise.
  always_comb begin
    nxt = upd;
    priority if (cls == scatr_pkg::CLS_IGNORED) begin
      nxt.phase = st.phase;
    end else if (terminal) begin
      nxt.phase = scatr_pkg::PH_DONE;
    end else if (cls == scatr_pkg::CLS_TS) begin
      nxt.phase = scatr_pkg::PH_T0;
    end else begin
      nxt.phase = scatr_pkg::PH_BODY;
    end
  end

  assign is_iface = (cls == scatr_pkg::CLS_TA) || (cls == scatr_pkg::CLS_TB) ||
                    (cls == scatr_pkg::CLS_TC) || (cls == scatr_pkg::CLS_TD);

  // Result fields for this byte.
  always_comb begin
    res.byte_class    = cls;
    res.group_number  = is_iface ? 3'(st.group) : 3'd0;
    res.protocol_type = upd.protocol;
    priority if (bad_ts)                    res.parse_status = scatr_pkg::ST_BAD_TS;
    else if (overflow)                      res.parse_status = scatr_pkg::ST_OVERFLOW;
    else if (cls == scatr_pkg::CLS_TCK) begin
      res.parse_status = (xor_new == 8'd0) ? scatr_pkg::ST_COMPLETE
                                           : scatr_pkg::ST_MISMATCH;
    end
    else if (complete)                      res.parse_status = scatr_pkg::ST_COMPLETE;
    else if (truncated)                     res.parse_status = scatr_pkg::ST_TRUNCATED;
    else                                    res.parse_status = scatr_pkg::ST_BUSY;
  end

endmodule

// File: dv/smart_card_atr_parser_core_tb.sv
// ----------------------------------------------------------------------------
// ATR parser core testbench
// Feeds answer-to-reset byte streams into the parser and checks the class,
// group, status and protocol reported for every byte. It compares them with
// a cycle-free model of the parse that runs as each byte is accepted. Most
// streams are well-formed ATRs with random content. Others are cut short,
// abandoned, restarted, overflowing or garbled. Both channels idle at random.
// ----------------------------------------------------------------------------
module smart_card_atr_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  // One byte offered on the input channel.
  typedef struct {
    logic [7:0]  b;
    logic        start;
    logic        last;
    int unsigned gap;
    bit          drain;
  } atr_item_t;

  // Classification expected back for one byte.
  typedef struct {
    logic [7:0]          value;
    scatr_pkg::class_t   cls;
    logic [2:0]          grp;
    scatr_pkg::status_t  st;
    logic [3:0]          proto;
  } byte_class_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  atr_byte_if   atr_ch ();
  atr_result_if res_ch ();

  smart_card_atr_parser_core uut (
    .clk (clk),
    .rst (rst),
    .atr (atr_ch),
    .res (res_ch)
  );

  atr_item_t   byte_feed[$];
  byte_class_t pending_classes[$];

  int          n_bytes_sent = 0;
  int          n_classes_checked = 0;
  int          n_errors = 0;
  int          n_atrs = 0;
  int          st_count[8];
  int          tx_calm = 0;
  int          rx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned tx_wait = 0;
  int          choke_left = 0;
  int          choke_mark = 300;

  // Parser model state, starting from its reset values.
  scatr_pkg::phase_t atr_phase = scatr_pkg::PH_TS;
  logic [3:0]  due_ind = 4'd0;
  logic [3:0]  hist_cnt = 4'd0;
  int          grp_cur = 0;
  logic [7:0]  xor_acc = 8'd0;
  logic [3:0]  proto_num = 4'd0;
  logic        tck_due = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the parse model by one accepted byte and return its class.
  function automatic byte_class_t classify_byte(logic [7:0] b, logic start, logic last);
    byte_class_t r;
    bit          fin;
    r.value = b;
    r.cls   = scatr_pkg::CLS_IGNORED;
    r.grp   = 3'd0;
    r.st    = scatr_pkg::ST_BUSY;
    fin     = 1'b0;
    if (start) begin
      atr_phase = scatr_pkg::PH_TS;
      due_ind   = 4'd0;
      hist_cnt  = 4'd0;
      grp_cur   = 0;
      xor_acc   = 8'd0;
      proto_num = 4'd0;
      tck_due   = 1'b0;
    end
    case (atr_phase)
      scatr_pkg::PH_TS: begin
        r.cls = scatr_pkg::CLS_TS;
        if (b != scatr_pkg::TsDirect && b != scatr_pkg::TsInverse) begin
          r.st = scatr_pkg::ST_BAD_TS;
          fin  = 1'b1;
        end else begin
          atr_phase = scatr_pkg::PH_T0;
        end
      end
      scatr_pkg::PH_T0: begin
        r.cls     = scatr_pkg::CLS_T0;
        xor_acc   ^= b;
        hist_cnt  = b[3:0];
        due_ind   = b[7:4];
        atr_phase = scatr_pkg::PH_BODY;
      end
      scatr_pkg::PH_BODY: begin
        xor_acc ^= b;
        if (due_ind != 4'd0) begin
          r.grp = grp_cur[2:0];
          if (due_ind[0]) begin
            r.cls      = scatr_pkg::CLS_TA;
            due_ind[0] = 1'b0;
          end else if (due_ind[1]) begin
            r.cls      = scatr_pkg::CLS_TB;
            due_ind[1] = 1'b0;
          end else if (due_ind[2]) begin
            r.cls      = scatr_pkg::CLS_TC;
            due_ind[2] = 1'b0;
          end else begin
            // TD: next indicators, protocol from the first group only.
            r.cls = scatr_pkg::CLS_TD;
            if (grp_cur == 0) proto_num = b[3:0];
            if (b[3:0] != 4'd0) tck_due = 1'b1;
            due_ind = b[7:4];
            if (due_ind != 4'd0) begin
              if (grp_cur + 1 >= scatr_pkg::MaxGroups) begin
                r.st = scatr_pkg::ST_OVERFLOW;
                fin  = 1'b1;
              end else begin
                grp_cur++;
              end
            end
          end
        end else if (hist_cnt != 4'd0) begin
          r.cls = scatr_pkg::CLS_HIST;
          hist_cnt--;
        end else begin
          // Only a TCK can follow once everything else is in.
          r.cls = scatr_pkg::CLS_TCK;
          r.st  = (xor_acc == 8'd0) ? scatr_pkg::ST_COMPLETE : scatr_pkg::ST_MISMATCH;
          fin   = 1'b1;
        end
      end
      default: r.cls = scatr_pkg::CLS_IGNORED;
    endcase
    if (r.cls != scatr_pkg::CLS_IGNORED) begin
      if (!fin && atr_phase == scatr_pkg::PH_BODY && due_ind == 4'd0 &&
          hist_cnt == 4'd0 && !tck_due) begin
        r.st = scatr_pkg::ST_COMPLETE;
        fin  = 1'b1;
      end
      if (!fin && last) begin
        r.st = scatr_pkg::ST_TRUNCATED;
        fin  = 1'b1;
      end
      if (fin) atr_phase = scatr_pkg::PH_DONE;
    end
    r.proto = proto_num;
    return r;
  endfunction

  // XOR of every byte after TS, which is what a correct TCK must equal.
  function automatic logic [7:0] xor_tail(byte_q_t seq);
    logic [7:0] acc;
    acc = 8'd0;
    for (int i = 1; i < seq.size(); i++) acc ^= seq[i];
    return acc;
  endfunction

  // Append a byte stream to the feed, drawing the sender's gap for each byte.
  task automatic queue_seq(input byte_q_t seq, input bit fresh, input int last_at,
                           input bit hold);
    atr_item_t it;
    for (int i = 0; i < seq.size(); i++) begin
      it.b     = seq[i];
      it.start = fresh && (i == 0);
      it.last  = (i == last_at);
      it.drain = hold && (i == 0);
      if (tx_calm > 0) begin
        it.gap = 0;
        tx_calm--;
      end else begin
        it.gap = $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 80);
      end
      byte_feed.push_back(it);
    end
    if (fresh) n_atrs++;
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: byte %0d %s mismatch: expected %0h, got %0h",
               $time, n_classes_checked, what, want, got);
      n_errors++;
    end
  endtask

  // Input driver: offers the feed's head once its gap and any drain are over.
  always @(posedge clk) begin : drive_atr
    atr_item_t it;
    bit        took;
    int        outstanding;
    int        waited;
    if (rst) begin
      atr_ch.valid <= 1'b0;
      tx_wait      <= 0;
    end else begin
      took = atr_ch.valid && atr_ch.ready;
      if (took) begin
        pending_classes.push_back(classify_byte(atr_ch.atr_byte, atr_ch.start_new,
                                                atr_ch.last_available));
        n_bytes_sent <= n_bytes_sent + 1;
      end
      outstanding = n_bytes_sent + int'(took) - n_classes_checked
                    - int'(res_ch.valid && res_ch.ready);
      waited = took ? 0 : tx_wait;
      if (!atr_ch.valid || took) begin
        if (byte_feed.size() > 0 && waited >= byte_feed[0].gap &&
            (!byte_feed[0].drain || outstanding == 0)) begin
          it = byte_feed.pop_front();
          atr_ch.valid          <= 1'b1;
          atr_ch.atr_byte       <= it.b;
          atr_ch.start_new      <= it.start;
          atr_ch.last_available <= it.last;
          tx_wait               <= 0;
        end else begin
          atr_ch.valid <= 1'b0;
          tx_wait      <= waited + 1;
        end
      end
    end
  end

  // Result monitor: checks each accepted item and draws the next stall.
  always @(posedge clk) begin : collect_class
    byte_class_t want;
    int unsigned stall;
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_stall     <= 0;
    end else begin
      stall = rx_stall;
      if (res_ch.valid && res_ch.ready) begin
        if (pending_classes.size() == 0) begin
          $display("%0t: unexpected result: byte %0h class %0d status %0d",
                   $time, res_ch.byte_value, res_ch.byte_class, res_ch.parse_status);
          n_errors++;
        end else begin
          want = pending_classes.pop_front();
          st_count[want.st]++;
          check_field("byte_value", want.value, res_ch.byte_value);
          check_field("byte_class", 8'(want.cls), 8'(res_ch.byte_class));
          check_field("group_number", 8'(want.grp), 8'(res_ch.group_number));
          check_field("parse_status", 8'(want.st), 8'(res_ch.parse_status));
          check_field("protocol_type", 8'(want.proto), 8'(res_ch.protocol_type));
        end
        n_classes_checked <= n_classes_checked + 1;
        if (rx_calm > 0) begin
          stall = 0;
          rx_calm--;
        end else begin
          stall = $urandom_range(0, 3);
          if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 80);
        end
      end else if (stall > 0) begin
        stall--;
      end
      rx_stall     <= stall;
      res_ch.ready <= (stall == 0) && (choke_left == 0);
    end
  end

  // Long receiver hold-offs so that the output backs up into the input.
  always @(posedge clk) begin : choke_ctl
    if (rst) begin
      choke_left <= 0;
    end else if (choke_left > 0) begin
      choke_left <= choke_left - 1;
    end else if (n_classes_checked >= choke_mark) begin
      choke_left <= 64;
      choke_mark <= choke_mark + 700;
    end
  end

  // Stimulus, then wait for the last result and report.
  initial begin : stimulus
    byte_q_t    seq;
    logic [3:0] ind;
    logic [3:0] k;
    logic [7:0] td;
    logic [7:0] tck;
    int         groups_max;
    int         g;
    int         mode;
    int         last_at;
    int         n;
    bit         need_tck;
    bit         more;
    bit         first_rand;

    atr_ch.valid          = 1'b0;
    atr_ch.atr_byte       = 8'd0;
    atr_ch.start_new      = 1'b0;
    atr_ch.last_available = 1'b0;
    res_ch.ready          = 1'b0;

    // First byte after reset is TS without start_new; T0 announces nothing;
    // a trailing byte is ignored.
    seq = '{8'h3B, 8'h00, 8'hAA};
    queue_seq(seq, 1'b0, -1, 1'b1);
    // Bad TS, then a byte that is ignored until the next restart.
    seq = '{8'h12, 8'h3F};
    queue_seq(seq, 1'b1, -1, 1'b0);
    // Full first group with extreme values, one historical byte and a good TCK.
    seq = '{8'h3F, 8'hF1, 8'h00, 8'hFF, 8'h55, 8'h01, 8'h80};
    seq.push_back(xor_tail(seq));
    queue_seq(seq, 1'b1, seq.size() - 1, 1'b0);
    // One group with a TA and a TD naming protocol E, and a corrupt TCK.
    seq = '{8'h3B, 8'h90, 8'h81, 8'h0E};
    seq.push_back(xor_tail(seq) ^ 8'h01);
    queue_seq(seq, 1'b1, -1, 1'b0);
    // Truncation inside the historical bytes and right at TS.
    seq = '{8'h3B, 8'h0F, 8'h00};
    queue_seq(seq, 1'b1, 2, 1'b0);
    seq = '{8'h3F};
    queue_seq(seq, 1'b1, 0, 1'b0);

    // Random part: mostly well-formed ATRs, some broken ones and some noise.
    first_rand = 1'b1;
    while (byte_feed.size() < 1930) begin
      seq.delete();
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) seq.push_back(8'($urandom));
        queue_seq(seq, $urandom_range(0, 7) == 0,
                  ($urandom_range(0, 7) == 0) ? n - 1 : -1, 1'b0);
      end else begin
        if ($urandom_range(0, 24) == 0) seq.push_back(8'($urandom));
        else seq.push_back($urandom_range(0, 1) ? scatr_pkg::TsDirect
                                                : scatr_pkg::TsInverse);
        k   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 3));
        ind = 4'($urandom_range(0, 15));
        seq.push_back({ind, k});
        groups_max = ($urandom_range(0, 9) == 0)
                     ? $urandom_range(scatr_pkg::MaxGroups, scatr_pkg::MaxGroups + 2)
                     : $urandom_range(1, 4);
        g        = 0;
        need_tck = 1'b0;
        do begin
          if (ind[0]) seq.push_back(8'($urandom));
          if (ind[1]) seq.push_back(8'($urandom));
          if (ind[2]) seq.push_back(8'($urandom));
          td = 8'd0;
          if (ind[3]) begin
            g++;
            td[3:0] = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
            td[7:4] = (g < groups_max) ? 4'($urandom_range(0, 15)) : 4'd0;
            if (td[3:0] != 4'd0) need_tck = 1'b1;
            seq.push_back(td);
          end
          more = ind[3];
          ind  = td[7:4];
        end while (more);
        repeat (k) seq.push_back(8'($urandom));
        if (need_tck) begin
          tck = xor_tail(seq);
          if ($urandom_range(0, 5) == 0) tck ^= 8'($urandom_range(1, 255));
          seq.push_back(tck);
        end
        // Cut short with last set, abandoned mid-way, sent without a restart,
        // or sent whole.
        mode = $urandom_range(0, 15);
        if (mode == 0 && seq.size() > 1) begin
          last_at = $urandom_range(0, seq.size() - 2);
          while (seq.size() > last_at + 1) seq.delete(seq.size() - 1);
        end else if (mode == 1 && seq.size() > 2) begin
          n = $urandom_range(1, seq.size() - 1);
          while (seq.size() > n) seq.delete(seq.size() - 1);
          last_at = -1;
        end else begin
          last_at = $urandom_range(0, 1) ? seq.size() - 1 : -1;
        end
        queue_seq(seq, mode != 2, last_at, first_rand || $urandom_range(0, 14) == 0);
        first_rand = 1'b0;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (byte_feed.size() != 0 || atr_ch.valid || n_bytes_sent != n_classes_checked);
    repeat (4) @(negedge clk);

    $display("Checked %0d classified bytes from %0d ATR streams under random stalls.",
             n_classes_checked, n_atrs);
    $display("Outcomes: %0d complete, %0d bad TS, %0d truncated, %0d TCK errors, %0d overflow.",
             st_count[scatr_pkg::ST_COMPLETE], st_count[scatr_pkg::ST_BAD_TS],
             st_count[scatr_pkg::ST_TRUNCATED], st_count[scatr_pkg::ST_MISMATCH],
             st_count[scatr_pkg::ST_OVERFLOW]);
    if (pending_classes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_classes.size());
    end
    if (n_errors == 0 && pending_classes.size() == 0) begin
      $display("smart_card_atr_parser_core_tb passed");
    end else begin
      $display("smart_card_atr_parser_core_tb failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("smart_card_atr_parser_core_tb failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/scatr_pkg.sv
hdl/atr_byte_if.sv
hdl/atr_result_if.sv
hdl/scatr_classify.sv
hdl/smart_card_atr_parser_core.sv
dv/smart_card_atr_parser_core_tb.sv
